>>> rtl/core/txr_pkg.sv
// Package: shared types and constants of the transmit ring packetizer.
package txr_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned POLL_W    = 8;
  localparam int unsigned FRAME_W   = 8;

  localparam logic [POLL_W-1:0] POLL_RESET = 8'd100;

  // Input commands; code 3 is unused and ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DONE = 2'd2
  } cmd_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_BYTE   = 2'd2,
    KIND_ZLP    = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/core/txr_if.sv
// Interfaces: command channel and result channel of the packetizer.
interface txr_in_if;
  logic                         valid;
  logic                         ready;
  logic [txr_pkg::CMD_W-1:0]    cmd;
  logic [txr_pkg::BYTE_W-1:0]   data_byte;
  logic                         link_up;

  modport source (output valid, output cmd, output data_byte, output link_up, input ready);
  modport sink   (input valid, input cmd, input data_byte, input link_up, output ready);
endinterface

interface txr_out_if;
  logic                         valid;
  logic                         ready;
  logic [txr_pkg::KIND_W-1:0]   kind;
  logic [txr_pkg::BYTE_W-1:0]   pkt_byte;
  logic                         pkt_last;
  logic [txr_pkg::LEN_W-1:0]    pkt_len;

  modport source (output valid, output kind, output pkt_byte, output pkt_last,
                  output pkt_len, input ready);
  modport sink   (input valid, input kind, input pkt_byte, input pkt_last,
                  input pkt_len, output ready);
endinterface

>>> rtl/core/txr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module txr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/usb_tx_ring_packetizer.sv
// Top level: transmit ring buffer that packs queued bytes into bulk IN packets.
// A put, a frame tick and an IN-done command are accepted whenever the result
// register is free or being drained in the same cycle. A tick that starts a
// packet of N bytes (1 to RING_DEPTH) holds off the command channel until its
// last byte is loaded: the ring RAM has one read port with registered read
// data, the first read is issued in the accept cycle and each further byte is
// read while the previous one moves into the result register, so the packet
// leaves at one byte per cycle when the sink does not stall. The ring contents
// are undefined after reset; only written entries are ever read.
module usb_tx_ring_packetizer #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  txr_in_if.sink                      req_i,
  txr_out_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [txr_pkg::POLL_W-1:0]  cfg_wdata_i
);
  import txr_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  state_e               state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        tail_q, tail_d;
  logic                 full_q, full_d;
  logic                 busy_q, busy_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic [POLL_W-1:0]    poll_q;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     len_q, len_d;

  // Result register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 out_last_q;
  logic [LEN_W-1:0]     out_len_q;

  logic                 load;
  kind_e                ld_kind;
  logic [BYTE_W-1:0]    ld_byte;
  logic                 ld_last;
  logic [LEN_W-1:0]     ld_len;

  logic                 slot_free;
  logic                 accept;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;
  logic [AW-1:0]        tail_inc;
  logic [AW-1:0]        ptr_inc;
  logic [LEN_W-1:0]     pend_len;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;
  assign tail_inc    = wrap_inc(tail_q);
  assign ptr_inc     = wrap_inc(ptr_q);

  // Pending byte count between head and tail, with wrap
  assign pend_len = (tail_q > head_q) ? (LEN_W'(tail_q) - LEN_W'(head_q))
                  : (LEN_W'(RING_DEPTH) - LEN_W'(head_q) + LEN_W'(tail_q));

  // Ring storage
  txr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (req_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command decode and packet sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    full_d    = full_q;
    busy_d    = busy_q;
    frame_d   = frame_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    len_d     = len_q;
    load      = 1'b0;
    ld_kind   = KIND_ACCEPT;
    ld_byte   = '0;
    ld_last   = 1'b0;
    ld_len    = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_PUT: begin
              load = 1'b1;
              if (full_q) begin
                ld_kind = KIND_REJECT;
              end else begin
                ram_we = 1'b1;
                tail_d = tail_inc;
                full_d = (tail_inc == head_q);
              end
            end
            CMD_TICK: begin
              if (req_i.link_up) begin
                frame_d = frame_q + FRAME_W'(1);
                if (frame_q > poll_q) begin
                  frame_d = '0;
                  if (!busy_q) begin
                    if (head_q == tail_q) begin
                      if (full_q) begin
                        busy_d  = 1'b1;
                        ram_re  = 1'b1;
                        ptr_d   = head_q;
                        rem_d   = LEN_W'(RING_DEPTH);
                        len_d   = LEN_W'(RING_DEPTH);
                        state_d = ST_EMIT;
                      end
                    end else begin
                      busy_d  = 1'b1;
                      ram_re  = 1'b1;
                      ptr_d   = head_q;
                      rem_d   = pend_len;
                      len_d   = pend_len;
                      head_d  = tail_q;
                      state_d = ST_EMIT;
                    end
                  end
                end
              end
            end
            CMD_DONE: begin
              if (full_q) begin
                full_d  = 1'b0;
                load    = 1'b1;
                ld_kind = KIND_ZLP;
                ld_last = 1'b1;
              end else begin
                busy_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        // Move the fetched byte out and fetch the next one
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = KIND_BYTE;
          ld_byte = ram_rdata;
          ld_last = (rem_q == LEN_W'(1));
          ld_len  = len_q;
          rem_d   = rem_q - LEN_W'(1);
          ptr_d   = ptr_inc;
          if (rem_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      full_q      <= 1'b0;
      busy_q      <= 1'b0;
      frame_q     <= '0;
      poll_q      <= POLL_RESET;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      full_q  <= full_d;
      busy_q  <= busy_d;
      frame_q <= frame_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        poll_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    len_q <= len_d;
    if (load) begin
      out_kind_q <= ld_kind;
      out_byte_q <= ld_byte;
      out_last_q <= ld_last;
      out_len_q  <= ld_len;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.kind     = out_kind_q;
  assign rsp_o.pkt_byte = out_byte_q;
  assign rsp_o.pkt_last = out_last_q;
  assign rsp_o.pkt_len  = out_len_q;

  // Checks
  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !req_i.ready)
    else $error("command accepted while a packet is being sent");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> busy_q && rem_q != '0)
    else $error("packet in flight without busy flag or byte count");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> head_q == tail_q)
    else $error("full flag set while head and tail differ");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && load && ld_last |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last byte");

endmodule

>>> dv/tb_usb_tx_ring_packetizer.sv
// Testbench: transmit ring packetizer checked against a cycle-free predictor in a scoreboard.
module tb_usb_tx_ring_packetizer;
  timeunit 1ns;
  timeprecision 1ps;

  import txr_pkg::*;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned TAIL_WAIT   = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One expected transfer on the result channel
  typedef struct {
    kind_e             kind;
    logic [BYTE_W-1:0] pkt_byte;
    logic              pkt_last;
    logic [LEN_W-1:0]  pkt_len;
  } tx_rsp_t;

  // Ring state mirror and expected result queue
  class tx_ring_scoreboard;
    logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    bit                 full;
    bit                 busy;
    logic [FRAME_W-1:0] frame_cnt;
    logic [POLL_W-1:0]  poll;
    tx_rsp_t            expected_q[$];
    int unsigned        errors;
    int unsigned        n_put;
    int unsigned        n_reject;
    int unsigned        n_pkt;
    int unsigned        n_byte;
    int unsigned        n_full_pkt;
    int unsigned        n_zlp;

    function new();
      head_idx   = 0;
      tail_idx   = 0;
      full       = 1'b0;
      busy       = 1'b0;
      frame_cnt  = '0;
      poll       = POLL_RESET;
      errors     = 0;
      n_put      = 0;
      n_reject   = 0;
      n_pkt      = 0;
      n_byte     = 0;
      n_full_pkt = 0;
      n_zlp      = 0;
    endfunction

    function int unsigned next_idx(int unsigned i);
      return (i == RING_DEPTH - 1) ? 0 : i + 1;
    endfunction

    function void push_rsp(kind_e k, logic [BYTE_W-1:0] b, logic last, int unsigned len);
      tx_rsp_t item;
      item.kind     = k;
      item.pkt_byte = b;
      item.pkt_last = last;
      item.pkt_len  = LEN_W'(len);
      expected_q.push_back(item);
    endfunction

    // Packet bytes read from the head onward, head itself not moved here
    function void queue_packet(int unsigned len);
      int unsigned p;
      p = head_idx;
      for (int unsigned i = 0; i < len; i++) begin
        push_rsp(KIND_BYTE, ring_mem[p], (i + 1 == len), len);
        p = next_idx(p);
      end
      n_pkt++;
      n_byte += len;
    endfunction

    // Update the mirror for one accepted command and queue its results
    function void note_input(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] d, logic link);
      logic [FRAME_W-1:0] old_cnt;
      int unsigned        len;
      case (c)
        CMD_PUT: begin
          if (full) begin
            push_rsp(KIND_REJECT, '0, 1'b0, 0);
            n_reject++;
          end else begin
            ring_mem[tail_idx] = d;
            tail_idx = next_idx(tail_idx);
            if (tail_idx == head_idx) full = 1'b1;
            push_rsp(KIND_ACCEPT, '0, 1'b0, 0);
            n_put++;
          end
        end
        CMD_TICK: begin
          if (link) begin
            old_cnt   = frame_cnt;
            frame_cnt = frame_cnt + 1'b1;
            if (old_cnt > poll) begin
              frame_cnt = '0;
              if (!busy) begin
                if (head_idx == tail_idx) begin
                  // empty ring sends nothing, full ring sends all of it
                  if (full) begin
                    busy = 1'b1;
                    queue_packet(RING_DEPTH);
                    n_full_pkt++;
                  end
                end else begin
                  busy = 1'b1;
                  len = (tail_idx > head_idx) ? tail_idx - head_idx
                                              : RING_DEPTH - head_idx + tail_idx;
                  queue_packet(len);
                  head_idx = tail_idx;
                end
              end
            end
          end
        end
        CMD_DONE: begin
          if (full) begin
            full = 1'b0;
            push_rsp(KIND_ZLP, '0, 1'b1, 0);
            n_zlp++;
          end else begin
            busy = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b, logic last,
                               logic [LEN_W-1:0] len);
      tx_rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: kind %0d byte %02h last %0d len %0d",
                 $time, k, b, last, len);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (k !== want.kind) begin
        $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, k);
        errors++;
      end
      if (b !== want.pkt_byte) begin
        $display("%0t: pkt_byte mismatch: expected %02h, actual %02h",
                 $time, want.pkt_byte, b);
        errors++;
      end
      if (last !== want.pkt_last) begin
        $display("%0t: pkt_last mismatch: expected %0d, actual %0d",
                 $time, want.pkt_last, last);
        errors++;
      end
      if (len !== want.pkt_len) begin
        $display("%0t: pkt_len mismatch: expected %0d, actual %0d", $time, want.pkt_len, len);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [POLL_W-1:0] cfg_wdata = '0;

  bit          no_gaps  = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned n_items  = 0;
  int unsigned cycle_cnt = 0;
  logic [POLL_W-1:0] mid_poll;

  tx_ring_scoreboard sb = new();

  txr_in_if  req_if ();
  txr_out_if rsp_if ();

  usb_tx_ring_packetizer #(
    .RING_DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, sb.expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result sink: random back-pressure, one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.kind, rsp_if.pkt_byte, rsp_if.pkt_last, rsp_if.pkt_len);
      end
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(99) < 29) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one command and wait for its transfer; valid stays high afterwards
  task automatic send_item(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] d, logic link);
    if (!no_gaps && $urandom_range(99) < 29) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 29);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= c;
    req_if.data_byte <= d;
    req_if.link_up   <= link;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_input(c, d, link);
    if (c != CMD_UNUSED) n_items++;
  endtask

  // Let the block run dry before touching the poll register
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_poll(logic [POLL_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.poll = value;
  endtask

  // Random command mix; unused commands are not counted
  task automatic run_mix(int unsigned n, int unsigned put_pct, int unsigned tick_pct,
                         int unsigned done_pct);
    int unsigned start;
    int unsigned roll;
    start = n_items;
    while (n_items - start < n) begin
      roll = $urandom_range(99);
      if (roll < put_pct) begin
        send_item(CMD_PUT, BYTE_W'($urandom), 1'($urandom_range(1)));
      end else if (roll < put_pct + tick_pct) begin
        send_item(CMD_TICK, BYTE_W'($urandom), ($urandom_range(99) < 92));
      end else if (roll < put_pct + tick_pct + done_pct) begin
        send_item(CMD_DONE, BYTE_W'($urandom), 1'($urandom_range(1)));
      end else begin
        send_item(CMD_UNUSED, BYTE_W'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  // Overfill the ring, then either ship it whole or drop it with a zero-length packet
  task automatic fill_ring(bit drop, bit hold);
    int unsigned n_fill;
    n_fill = $urandom_range(66, 70);
    // first IN done drops a leftover fill, second one clears busy
    send_item(CMD_DONE, BYTE_W'($urandom), 1'b1);
    send_item(CMD_DONE, BYTE_W'($urandom), 1'b1);
    if (hold) hold_req = 1'b1;
    repeat (n_fill) send_item(CMD_PUT, BYTE_W'($urandom), 1'($urandom_range(1)));
    if (drop) begin
      send_item(CMD_DONE, BYTE_W'($urandom), 1'b0);
    end else begin
      repeat (4) send_item(CMD_TICK, BYTE_W'($urandom), 1'b1);
    end
    send_item(CMD_DONE, BYTE_W'($urandom), 1'b1);
    send_item(CMD_DONE, BYTE_W'($urandom), 1'b0);
  endtask

  // Stimulus
  initial begin : stimulus
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_PUT;
    req_if.data_byte <= '0;
    req_if.link_up   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, poll at its reset value: byte extremes, ignored commands
    send_item(CMD_PUT, 8'h00, 1'b0);
    send_item(CMD_PUT, 8'hFF, 1'b1);
    send_item(CMD_TICK, 8'h5A, 1'b0);
    send_item(CMD_UNUSED, 8'hA5, 1'b1);
    send_item(CMD_DONE, 8'h00, 1'b1);

    // Mostly ticks so the default threshold is crossed
    run_mix(140, 12, 84, 4);

    // Directed, poll 0: packet every second tick, put while busy, busy and empty ticks
    write_poll(8'd0);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'hFF, 1'b1);
    send_item(CMD_PUT, 8'h3C, 1'b1);
    send_item(CMD_PUT, 8'hC3, 1'b0);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_DONE, 8'h00, 1'b0);
    send_item(CMD_DONE, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_DONE, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);

    // Whole-ring packet while the sink holds off
    write_poll(8'd1);
    run_mix(15, 45, 35, 15);
    fill_ring(1'b0, 1'b1);
    run_mix(25, 45, 35, 15);

    // Back-to-back stretch, fill dropped by an IN done
    write_poll(8'd3);
    no_gaps = 1'b1;
    run_mix(15, 45, 35, 15);
    fill_ring(1'b1, 1'b0);
    run_mix(25, 45, 35, 15);
    no_gaps = 1'b0;

    mid_poll = POLL_W'($urandom_range(2, 12));
    write_poll(mid_poll);
    run_mix(20, 45, 35, 15);

    // Top thresholds, the last one never sends
    write_poll(8'd254);
    run_mix(20, 20, 75, 5);
    write_poll(8'd255);
    run_mix(12, 20, 75, 5);

    settle();
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Covered %0d commands: %0d puts stored, %0d refused while full, %0d packets",
             n_items, sb.n_put, sb.n_reject, sb.n_pkt);
    $display("with %0d bytes (%0d whole-ring), %0d zero-length; poll 100, 0, 1, 3, %0d, 254, 255",
             sb.n_byte, sb.n_full_pkt, sb.n_zlp, mid_poll);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
